[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising edge of clk.
// Each check is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge.
`define B64E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond never holds.
`define B64E_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/b64e_pkg.sv]
`timescale 1ns / 1ps
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One queued job: up to four characters from one input byte.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      cnt_m1;   // number of characters minus one
		logic            last;     // job ends the message
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Map a 6-bit value to its character in the standard alphabet.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, v};
		if (v < 6'd26) begin
			c = 8'h41 + w;
		end else if (v < 6'd52) begin
			c = 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

[rtl/b64e_front.sv]
`timescale 1ns / 1ps
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // end_of_message
	input  b64e_pkg::fifo_stat_t fifo_stat,
	output logic              push,
	output b64e_pkg::job_t    job,
	output logic [1:0]        phase
);
	import b64e_pkg::*;

	logic [3:0] pending_q;
	logic [1:0] phase_q;
	logic [3:0] pending_d;
	logic [1:0] phase_d;
	logic [7:0] b;

	assign b        = s_tdata;
	assign s_tready = !fifo_stat.full;
	assign push     = s_tvalid && s_tready;
	assign phase    = phase_q;

	// Classify the byte by group position and build its characters.
	always_comb begin
		job.chars  = '{default: PAD_CHAR};
		job.cnt_m1 = 2'd0;
		job.last   = s_tlast;
		pending_d  = 4'd0;
		phase_d    = 2'd0;
		unique case (phase_q)
			2'd1: begin
				job.chars[0] = enc_char({pending_q[1:0], b[7:4]});
				pending_d    = b[3:0];
				phase_d      = 2'd2;
				if (s_tlast) begin
					job.chars[1] = enc_char({b[3:0], 2'b00});
					job.cnt_m1   = 2'd2;
				end
			end
			2'd2: begin
				job.chars[0] = enc_char({pending_q, b[7:6]});
				job.chars[1] = enc_char(b[5:0]);
				job.cnt_m1   = 2'd1;
			end
			default: begin
				// an unreachable phase three counts as a fresh group
				job.chars[0] = enc_char(b[7:2]);
				pending_d    = {2'b00, b[1:0]};
				phase_d      = 2'd1;
				if (s_tlast) begin
					job.chars[1] = enc_char({b[1:0], 4'b0000});
					job.cnt_m1   = 2'd3;
				end
			end
		endcase
		if (s_tlast) begin
			pending_d = 4'd0;
			phase_d   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
			phase_q   <= 2'd0;
		end else if (push) begin
			pending_q <= pending_d;
			phase_q   <= phase_d;
		end
	end

endmodule

[rtl/b64e_fifo.sv]
`timescale 1ns / 1ps
module b64e_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64e_pkg::job_t       wr_job,
	input  logic                 pop,
	output b64e_pkg::job_t       rd_job,
	output b64e_pkg::fifo_stat_t stat
);
	import b64e_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_job     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/b64e_back.sv]
`timescale 1ns / 1ps
module b64e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64e_pkg::job_t       rd_job,
	input  b64e_pkg::fifo_stat_t fifo_stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] code_char
	output logic                 m_tlast    // final_char
);
	import b64e_pkg::*;

	job_t       job_q;
	logic       job_v_q;
	logic [1:0] idx_q;
	logic       m_tvalid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       out_free;
	logic       emit;
	logic       done;

	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = job_v_q && out_free;
	assign done     = emit && (idx_q == job_q.cnt_m1);
	assign pop      = !fifo_stat.empty && (!job_v_q || done);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q    <= 1'b0;
			idx_q      <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_v_q <= 1'b1;
				idx_q   <= 2'd0;
			end else if (done) begin
				job_v_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= rd_job;
		end
		if (emit) begin
			char_q <= job_q.chars[idx_q];
			last_q <= job_q.last && (idx_q == job_q.cnt_m1);
		end
	end

endmodule

[rtl/base64_stream_encoder.sv]
`timescale 1ns / 1ps
// Streaming base64 encoder (standard alphabet, '=' padding). Each input transfer
// carries one message byte, with tlast on the message's final byte; each output
// transfer carries one ASCII character, with tlast on the message's final
// character. A byte yields one or two characters, and the final byte yields two
// to four, padded to a multiple of four characters per message. The front end
// takes one byte per cycle while its job queue (FIFO_DEPTH entries) has room.
// The back end sends one character per cycle while m_tready allows, so the
// output port sets the sustained rate on long messages. A byte passes the job
// queue, job register and character register on its way out. No reset pass.
module base64_stream_encoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] code_char
	output logic       m_tlast    // final_char
);
	import b64e_pkg::*;

	`include "assert_macros.svh"

	job_t       wr_job;
	job_t       rd_job;
	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	logic [1:0] phase;

	// Front end: track group position, turn each byte into a character job.
	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.fifo_stat (fifo_stat),
		.push      (push),
		.job       (wr_job),
		.phase     (phase)
	);

	// Job queue: decouple byte intake from character output.
	b64e_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (fifo_stat)
	);

	// Back end: send the characters of each job one per cycle while m_tready allows.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_job    (rd_job),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// A message's last byte restarts the group.
	`B64E_ASSERT(a_eom_restart, (s_tvalid && s_tready && s_tlast) |=> (phase == 2'd0), "group not restarted after end of message")
	// A third byte closes the group.
	`B64E_ASSERT(a_group_close, (s_tvalid && s_tready && (phase == 2'd2)) |=> (phase == 2'd0), "group not closed after third byte")
	// The queue is never both full and empty.
	`B64E_NEVER(a_fifo_stat, (fifo_stat.full && fifo_stat.empty), "queue status inconsistent")
	// The back end never pulls from an empty queue.
	`B64E_NEVER(a_no_empty_pop, (pop && fifo_stat.empty), "pop from empty queue")

endmodule
